// ===== rtl/core/fwa_pkg.sv =====
// Shared types, constants and table functions of the frame window block.
package fwa_pkg;

    localparam int MAX_FRAME_DEF       = 16384;
    localparam int COS_TABLE_DEPTH_DEF = 1024;
    localparam int SAMPLE_WIDTH_DEF    = 16;

    localparam int KIND_W     = 2;
    localparam int LEN_W      = 15;
    localparam int POS_W      = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;
    localparam int COS_W      = 17;
    localparam int COEF_W     = 16;
    localparam int WIN_W      = 15;
    localparam int ACC_W      = 35;
    localparam int PHASE_W    = 32;

    localparam logic [LEN_W-1:0] FRAME_LENGTH_RESET = LEN_W'(1024);

    localparam logic [COEF_W-1:0] Q_HALF = 16'd32768;
    localparam logic [COEF_W-1:0] Q_054  = 16'd35389;
    localparam logic [COEF_W-1:0] Q_046  = 16'd30147;
    localparam logic [COEF_W-1:0] Q_042  = 16'd27525;
    localparam logic [COEF_W-1:0] Q_008  = 16'd5243;
    localparam logic [COEF_W-1:0] Q_ZERO = 16'd0;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

    typedef enum logic [KIND_W-1:0] {
        WIN_RECT,
        WIN_HANN,
        WIN_HAMMING,
        WIN_BLACKMAN
    } win_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_KIND,
        REG_FRAME_LENGTH
    } cfg_reg_t;

    typedef struct packed {
        logic [COEF_W-1:0] a;
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] c;
    } fwa_coef_t;

    typedef struct packed {
        logic accept;
        logic cos2;
        logic mac;
        logic coef;
        logic prod;
        logic load_out;
    } fwa_cmd_t;

    function automatic fwa_coef_t win_coef(input win_kind_t kind);
        fwa_coef_t coef;
        unique case (kind)
            WIN_RECT, WIN_HANN: coef = '{a: Q_HALF, b: Q_HALF, c: Q_ZERO};
            WIN_HAMMING:        coef = '{a: Q_054, b: Q_046, c: Q_ZERO};
            WIN_BLACKMAN:       coef = '{a: Q_042, b: Q_HALF, c: Q_008};
        endcase
        return coef;
    endfunction

    // cos(pi/2 * k / 2^aw) in unsigned Q1.16, integer Taylor series in Q30
    function automatic logic [COS_W-1:0] cos_entry(input int unsigned k, input int unsigned aw);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned rnd;
        longint          sum;
        int              n;
        x    = (HALF_PI_Q30 * 64'(k) + ((64'd1 << aw) >> 1)) >> aw;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (n = 0; n < 8; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if ((n & 1) == 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        rnd = ($unsigned(sum) + (64'd1 << 13)) >> 14;
        return COS_W'(rnd);
    endfunction

endpackage

// ===== rtl/core/fwa_step_div.sv =====
// Bit-serial divider that forms the rounded phase step 2^32 / (N-1).
module fwa_step_div #(
    parameter int DIV_W = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [DIV_W-1:0]              divisor,
    output logic                          busy,
    output logic [fwa_pkg::PHASE_W-1:0]   quotient
);

    localparam int NUM_W  = fwa_pkg::PHASE_W + 1;
    localparam int STEPS  = NUM_W;
    localparam int STEP_W = $clog2(STEPS);

    typedef enum logic [1:0] {
        DIV_LOAD,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    div_state_t          state_reg;
    logic [DIV_W-1:0]    divisor_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [STEP_W-1:0]   step_reg;

    logic [DIV_W:0]      shifted;
    logic [DIV_W+1:0]    diff;
    logic                fits;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor_reg};
    assign fits    = !diff[DIV_W+1];

    assign busy     = (state_reg != DIV_DONE);
    assign quotient = num_reg[NUM_W-2:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_LOAD;
        end else if (start) begin
            state_reg <= DIV_LOAD;
        end else begin
            unique case (state_reg)
                DIV_LOAD: begin
                    divisor_reg <= divisor;
                    rem_reg     <= '0;
                    num_reg     <= {1'b1, {(NUM_W-1){1'b0}}} + NUM_W'(divisor >> 1);
                    step_reg    <= STEP_W'(STEPS - 1);
                    state_reg   <= DIV_RUN;
                end
                DIV_RUN: begin
                    rem_reg <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
                    num_reg <= {num_reg[NUM_W-2:0], fits};
                    if (step_reg == '0) begin
                        state_reg <= DIV_DONE;
                    end else begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                DIV_DONE: begin
                    state_reg <= DIV_DONE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/fwa_ctrl.sv =====
// Sequencing state machine and output handshake of the frame window block.
module fwa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  logic               div_busy,
    output fwa_pkg::fwa_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COS2,
        ST_MAC,
        ST_COEF,
        ST_PROD,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    assign s_ready = (state_reg == ST_IDLE) && !div_busy;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.accept   = s_valid && s_ready;
        cmd.cos2     = (state_reg == ST_COS2);
        cmd.mac      = (state_reg == ST_MAC);
        cmd.coef     = (state_reg == ST_COEF);
        cmd.prod     = (state_reg == ST_PROD);
        cmd.load_out = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd.accept) begin
                        state_reg <= ST_COS2;
                    end
                end
                ST_COS2: state_reg <= ST_MAC;
                ST_MAC:  state_reg <= ST_COEF;
                ST_COEF: state_reg <= ST_PROD;
                ST_PROD: state_reg <= ST_OUT;
                ST_OUT: begin
                    if (cmd.load_out) begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/fwa_datapath.sv =====
// Registers, position counter, cosine table and arithmetic of the frame window block.
module fwa_datapath #(
    parameter int MAX_FRAME       = fwa_pkg::MAX_FRAME_DEF,
    parameter int COS_TABLE_DEPTH = fwa_pkg::COS_TABLE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH    = fwa_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [fwa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fwa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  fwa_pkg::fwa_cmd_t                 cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
    output logic                              div_busy,
    output logic signed [SAMPLE_WIDTH-1:0]    windowed_sample,
    output logic [fwa_pkg::POS_W-1:0]         frame_position,
    output logic                              last_of_frame
);

    localparam int CNT_W   = $clog2(MAX_FRAME);
    localparam int CMP_W   = (fwa_pkg::LEN_W > CNT_W + 1) ? fwa_pkg::LEN_W : CNT_W + 1;
    localparam int AW      = $clog2(COS_TABLE_DEPTH);
    localparam int ADDR_W  = AW + 1;
    localparam int IDX_W   = AW + 2;
    localparam int RSH     = fwa_pkg::PHASE_W - IDX_W;
    localparam int PW      = SAMPLE_WIDTH + fwa_pkg::COEF_W;
    localparam int YW      = SAMPLE_WIDTH + 2;
    localparam int ACC_W   = fwa_pkg::ACC_W;
    localparam int PHASE_W = fwa_pkg::PHASE_W;
    localparam int WIN_W   = fwa_pkg::WIN_W;
    localparam int COS_W   = fwa_pkg::COS_W;
    localparam int COEF_W  = fwa_pkg::COEF_W;
    localparam int WFULL_W = ACC_W - 17;

    localparam logic [PHASE_W:0]      PHASE_RND  = (PHASE_W + 1)'(1) << (RSH - 1);
    localparam logic [ADDR_W-1:0]     QUARTER    = ADDR_W'(COS_TABLE_DEPTH);
    localparam logic [CMP_W-1:0]      N_MIN      = CMP_W'(2);
    localparam logic [CMP_W-1:0]      N_MAX      = CMP_W'(MAX_FRAME);
    localparam logic [ACC_W-1:0]      ACC_RND    = ACC_W'(1) << 16;
    localparam logic [WFULL_W-1:0]    W_MAX_FULL = WFULL_W'(32767);
    localparam logic [PW:0]           PROD_RND   = (PW + 1)'(1) << 14;
    localparam logic signed [YW-1:0]  Y_MAX      = {3'b000, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [YW-1:0]  Y_MIN      = {3'b111, {(SAMPLE_WIDTH-1){1'b0}}};

    fwa_pkg::win_kind_t           window_kind_reg;
    logic [fwa_pkg::LEN_W-1:0]    frame_length_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [PHASE_W-1:0]           phase_acc_reg;
    logic [PHASE_W-1:0]           step_reg;

    fwa_pkg::win_kind_t           kind_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic [CNT_W-1:0]             pos_reg;
    logic                         last_reg;
    logic [PHASE_W-1:0]           phase_reg;
    logic [COS_W-1:0]             rom_q_reg;
    logic                         neg_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic [WIN_W-1:0]             w_reg;
    logic signed [PW-1:0]         prod_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic [CNT_W-1:0]             out_pos_reg;
    logic                         out_last_reg;

    logic [CMP_W-1:0]             len_ext;
    logic [CMP_W-1:0]             n_clamped;
    logic [CMP_W-1:0]             n_m1_wide;
    logic [CNT_W-1:0]             n_m1;
    logic                         last;
    logic [PHASE_W-1:0]           div_q;
    logic [PHASE_W-1:0]           step_use;
    logic                         div_start;

    logic [COS_W-1:0]             cos_tbl [COS_TABLE_DEPTH+1];
    logic [PHASE_W-1:0]           phase_sel;
    logic [PHASE_W:0]             phase_rnd;
    logic [IDX_W-1:0]             rom_idx;
    logic [1:0]                   quad;
    logic [ADDR_W-1:0]            rom_addr;

    fwa_pkg::fwa_coef_t           coef;
    logic [COEF_W-1:0]            mul_coef;
    logic [COEF_W+COS_W-1:0]      mul_p;
    logic signed [ACC_W-1:0]      acc_base;
    logic signed [ACC_W-1:0]      acc_term;
    logic                         acc_add;
    logic signed [ACC_W-1:0]      acc_next;
    logic [ACC_W-1:0]             acc_rnd;
    logic [WFULL_W-1:0]           w_full;
    logic [WIN_W-1:0]             w_next;
    logic signed [PW:0]           prod_biased;
    logic signed [YW-1:0]         y_wide;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;

    // frame length clamp and end-of-frame test
    always_comb begin
        len_ext = CMP_W'(frame_length_reg);
        if (len_ext < N_MIN) begin
            n_clamped = N_MIN;
        end else if (len_ext > N_MAX) begin
            n_clamped = N_MAX;
        end else begin
            n_clamped = len_ext;
        end
        n_m1_wide = n_clamped - 1'b1;
        n_m1      = n_m1_wide[CNT_W-1:0];
        last      = (count_reg >= n_m1);
        step_use  = (count_reg == '0) ? div_q : step_reg;
    end

    assign div_start = cfg_we && (cfg_index == fwa_pkg::REG_FRAME_LENGTH);

    fwa_step_div #(
        .DIV_W (CNT_W)
    ) u_step_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (n_m1),
        .busy     (div_busy),
        .quotient (div_q)
    );

    for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_cos
        assign cos_tbl[k] = fwa_pkg::cos_entry(k, AW);
    end

    // quarter-wave table address with quadrant folding
    always_comb begin
        phase_sel = cmd.cos2 ? {phase_reg[PHASE_W-2:0], 1'b0} : phase_acc_reg;
        phase_rnd = {1'b0, phase_sel} + PHASE_RND;
        rom_idx   = phase_rnd[PHASE_W-1:RSH];
        quad      = rom_idx[IDX_W-1:AW];
        if (quad[0]) begin
            rom_addr = QUARTER - {1'b0, rom_idx[AW-1:0]};
        end else begin
            rom_addr = {1'b0, rom_idx[AW-1:0]};
        end
    end

    // window sum A - B*cos(t) + C*cos(2t) on one shared multiplier
    always_comb begin
        coef     = fwa_pkg::win_coef(kind_reg);
        mul_coef = cmd.cos2 ? coef.b : coef.c;
        mul_p    = mul_coef * rom_q_reg;
        acc_base = cmd.cos2 ? $signed({3'b000, coef.a, 16'h0000}) : acc_reg;
        acc_term = $signed({2'b00, mul_p});
        acc_add  = neg_reg ^ cmd.mac;
        acc_next = acc_add ? (acc_base + acc_term) : (acc_base - acc_term);
    end

    always_comb begin
        acc_rnd = $unsigned(acc_reg) + ACC_RND;
        w_full  = acc_rnd[ACC_W-1:17];
        if (acc_reg[ACC_W-1]) begin
            w_next = '0;
        end else if (w_full > W_MAX_FULL) begin
            w_next = W_MAX_FULL[WIN_W-1:0];
        end else begin
            w_next = w_full[WIN_W-1:0];
        end
    end

    always_comb begin
        prod_biased = (PW + 1)'(prod_reg) + $signed(PROD_RND);
        y_wide      = $signed(prod_biased[PW:15]);
        if (y_wide > Y_MAX) begin
            y_sat = Y_MAX[SAMPLE_WIDTH-1:0];
        end else if (y_wide < Y_MIN) begin
            y_sat = Y_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            y_sat = y_wide[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_kind_reg  <= fwa_pkg::WIN_RECT;
            frame_length_reg <= fwa_pkg::FRAME_LENGTH_RESET;
            count_reg        <= '0;
            phase_acc_reg    <= '0;
            step_reg         <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == fwa_pkg::REG_WINDOW_KIND) begin
                    window_kind_reg <= fwa_pkg::win_kind_t'(cfg_data[fwa_pkg::KIND_W-1:0]);
                end else begin
                    frame_length_reg <= cfg_data[fwa_pkg::LEN_W-1:0];
                end
            end
            if (cmd.accept) begin
                if (count_reg == '0) begin
                    step_reg <= div_q;
                end
                count_reg     <= last ? '0 : count_reg + 1'b1;
                phase_acc_reg <= last ? '0 : phase_acc_reg + step_use;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rom_q_reg <= cos_tbl[rom_addr];
        neg_reg   <= quad[1] ^ quad[0];
        if (cmd.accept) begin
            kind_reg   <= window_kind_reg;
            sample_reg <= sample_in;
            pos_reg    <= count_reg;
            last_reg   <= last;
            phase_reg  <= phase_acc_reg;
        end
        if (cmd.cos2 || cmd.mac) begin
            acc_reg <= acc_next;
        end
        if (cmd.coef) begin
            w_reg <= w_next;
        end
        if (cmd.prod) begin
            prod_reg <= sample_reg * $signed({1'b0, w_reg});
        end
        if (cmd.load_out) begin
            out_sample_reg <= (kind_reg == fwa_pkg::WIN_RECT) ? sample_reg : y_sat;
            out_pos_reg    <= pos_reg;
            out_last_reg   <= last_reg;
        end
    end

    assign windowed_sample = out_sample_reg;
    assign frame_position  = fwa_pkg::POS_W'(out_pos_reg);
    assign last_of_frame   = out_last_reg;

endmodule

// ===== rtl/core/frame_window_apply.sv =====
// Top level of the frame window block: rectangle, Hann, Hamming or Blackman window.
// Each sample passes through five sequencing steps, cos2, mac, coef, prod and out, and
// the out step waits while a held result is not taken; a new sample is accepted only
// in idle, once the last result is loaded. The phase-step divider forms its quotient,
// one quotient bit a cycle, after reset and after each frame_length write; s_ready stays low meanwhile.
// Reset: rectangle window, frame length 1024, position and phase step zero.
module frame_window_apply #(
    parameter int MAX_FRAME       = fwa_pkg::MAX_FRAME_DEF,
    parameter int COS_TABLE_DEPTH = fwa_pkg::COS_TABLE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH    = fwa_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [fwa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fwa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_sample_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    m_windowed_sample,
    output logic [fwa_pkg::POS_W-1:0]         m_frame_position,
    output logic                              m_last_of_frame
);

    fwa_pkg::fwa_cmd_t cmd;
    logic              div_busy;

    fwa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .div_busy (div_busy),
        .cmd      (cmd)
    );

    fwa_datapath #(
        .MAX_FRAME       (MAX_FRAME),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .sample_in       (s_sample_in),
        .div_busy        (div_busy),
        .windowed_sample (m_windowed_sample),
        .frame_position  (m_frame_position),
        .last_of_frame   (m_last_of_frame)
    );

endmodule
